// ----- sv/fcsm_pkg.sv -----
// ----------------------------------------------------------------------------
// fcsm_pkg
// Shared types and constants for the four-channel sample mixer.
// ----------------------------------------------------------------------------
package fcsm_pkg;

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_REG    = 2'd1;
    localparam logic [1:0] REQ_MIX    = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [2:0] SEL_PERIOD   = 3'd0;
    localparam logic [2:0] SEL_VOLUME   = 3'd1;
    localparam logic [2:0] SEL_START    = 3'd2;
    localparam logic [2:0] SEL_LENGTH   = 3'd3;
    localparam logic [2:0] SEL_LOOP_OFS = 3'd4;
    localparam logic [2:0] SEL_LOOP_LEN = 3'd5;
    localparam logic [2:0] SEL_POSITION = 3'd6;
    localparam logic [2:0] SEL_ACTIVE   = 3'd7;

    localparam logic [1:0] CFG_RATE   = 2'd0;
    localparam logic [1:0] CFG_FEN    = 2'd1;
    localparam logic [1:0] CFG_ALPHA  = 2'd2;

    localparam logic [16:0] RATE_RESET  = 17'd44100;
    localparam logic [15:0] ALPHA_RESET = 16'd25258;

    // clock constant shifted into 16.16: 3546895 << 16
    localparam logic [37:0] STEP_NUM = 38'd3546895 << 16;

    // controller to datapath commands
    typedef struct packed {
        logic       load_req;     // capture request and apply writes
        logic       div_start;    // begin step division
        logic       ch_prep;      // channel stage 0: wrap check, issue read
        logic       ch_acc;       // channel stage 1: accumulate, advance
        logic [1:0] ch_idx;
        logic       filt_mul;     // start filter multiply
        logic       filt_fin;     // finish filter, produce outputs
    } fcsm_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       div_busy;
        logic       fen;
    } fcsm_stat_t;

endpackage

// ----- sv/four_channel_sample_mixer_core.sv -----
// ----------------------------------------------------------------------------
// four_channel_sample_mixer_core
// Four-channel sample playback mixer with stereo output and low-pass filter.
// ----------------------------------------------------------------------------
// Each beat is handled one at a time. A sample write or a plain register
// write passes through the decode state only; a period write also waits
// for the one-bit-per-cycle step divider; a mix beat runs a prep and an
// accumulate state per channel (with the sample memory read), then a filter
// multiply and output stage, and its result then waits in the output register.
module four_channel_sample_mixer_core #(
    parameter int SAMPLE_ADDR_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] req_type, [3:2] channel, [6:4] reg_sel, [22:7] address, [38:23] value
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] left_sample, [31:16] right_sample, [35:32] active_mask
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    fcsm_pkg::fcsm_cmd_t  cmd;
    fcsm_pkg::fcsm_stat_t stat;

    logic [16:0] rate_reg;
    logic        fen_reg;
    logic [15:0] alpha_reg;
    logic [15:0] left_sample, right_sample;
    logic [3:0]  active_mask;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg  <= fcsm_pkg::RATE_RESET;
            fen_reg   <= 1'b1;
            alpha_reg <= fcsm_pkg::ALPHA_RESET;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            unique case (cfg_idx)
                fcsm_pkg::CFG_RATE:  rate_reg  <= pwdata[16:0];
                fcsm_pkg::CFG_FEN:   fen_reg   <= pwdata[0];
                fcsm_pkg::CFG_ALPHA: alpha_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            fcsm_pkg::CFG_RATE:  prdata = {15'd0, rate_reg};
            fcsm_pkg::CFG_FEN:   prdata = {31'd0, fen_reg};
            fcsm_pkg::CFG_ALPHA: prdata = {16'd0, alpha_reg};
            default:             prdata = 32'd0;
        endcase
    end

    fcsm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_tvalid && s_tready),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .stat      (stat),
        .cmd       (cmd)
    );

    fcsm_datapath #(
        .SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .in_req_type   (s_tdata[1:0]),
        .in_channel    (s_tdata[3:2]),
        .in_reg_sel    (s_tdata[6:4]),
        .in_address    (s_tdata[22:7]),
        .in_value      (s_tdata[38:23]),
        .frame_rate    (rate_reg),
        .filter_enable (fen_reg),
        .filter_alpha  (alpha_reg),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .active_mask   (active_mask)
    );

    assign m_tdata = {4'd0, active_mask, right_sample, left_sample};

endmodule

// ----- sv/fcsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// fcsm_ctrl
// Sequencer: accepts a request, steps the datapath through it, holds result.
// ----------------------------------------------------------------------------
module fcsm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    output logic                 in_ready,
    input  logic                 out_ready,
    output logic                 out_valid,
    input  fcsm_pkg::fcsm_stat_t stat,
    output fcsm_pkg::fcsm_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEC  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_FMUL = 3'd5;
    localparam logic [2:0] ST_FFIN = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] ch_reg, ch_next;
    logic       ovalid_reg, ovalid_next;

    // next result may be computed while previous waits only until finish
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;

    always_comb begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        cmd.ch_idx  = ch_reg;
        if (ovalid_reg && out_ready) begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DEC;
                end
            end
            ST_DEC: begin
                ch_next = 2'd0;
                if (stat.req_type == fcsm_pkg::REQ_MIX) begin
                    state_next = ST_PREP;
                end else if (stat.div_busy) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (!stat.div_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_PREP: begin
                cmd.ch_prep = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.ch_acc = 1'b1;
                ch_next    = ch_reg + 2'd1;
                state_next = (ch_reg == 2'd3) ? ST_FMUL : ST_PREP;
            end
            ST_FMUL: begin
                cmd.filt_mul = 1'b1;
                state_next   = ST_FFIN;
            end
            ST_FFIN: begin
                // wait for output register to be free
                if (!ovalid_reg || out_ready) begin
                    cmd.filt_fin = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ch_reg     <= 2'd0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ch_reg     <= ch_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// ----- sv/fcsm_div.sv -----
// ----------------------------------------------------------------------------
// fcsm_div
// Restoring divider, one quotient bit per cycle, for the playback step.
// ----------------------------------------------------------------------------
module fcsm_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] period,
    input  logic [16:0] rate,
    output logic        busy,
    output logic [31:0] step
);

    localparam int NB = 38;

    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [NB-1:0] quo_reg, quo_next;
    logic [NB-1:0] rem_reg, rem_next;
    logic [34:0] den_reg, den_next;
    logic        zero_reg, zero_next;
    logic [NB:0] trial;
    logic [NB-1:0] shifted;

    assign busy = busy_reg;
    assign step = zero_reg ? 32'd0 :
                  ((|quo_reg[NB-1:32]) ? 32'hFFFF_FFFF : quo_reg[31:0]);

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        zero_next = zero_reg;
        shifted   = {rem_reg[NB-2:0], quo_reg[NB-1]};
        trial     = {1'b0, shifted} - {4'd0, den_reg};
        if (start) begin
            // den = 2*period*rate; multiplier 16x17
            den_next  = {1'b0, 33'(period) * 33'(rate), 1'b0};
            zero_next = (period == 16'd0) || (rate == 17'd0);
            quo_next  = fcsm_pkg::STEP_NUM;
            rem_next  = '0;
            cnt_next  = 6'(NB);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[NB]) begin
                rem_next = trial[NB-1:0];
                quo_next = {quo_reg[NB-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            zero_reg <= 1'b1;
            quo_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            zero_reg <= zero_next;
            quo_reg  <= quo_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

// ----- sv/fcsm_datapath.sv -----
// ----------------------------------------------------------------------------
// fcsm_datapath
// Sample memory, channel registers, mix accumulators, low-pass and output.
// ----------------------------------------------------------------------------
module fcsm_datapath #(
    parameter int SAMPLE_ADDR_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fcsm_pkg::fcsm_cmd_t  cmd,
    output fcsm_pkg::fcsm_stat_t stat,
    input  logic [1:0]           in_req_type,
    input  logic [1:0]           in_channel,
    input  logic [2:0]           in_reg_sel,
    input  logic [15:0]          in_address,
    input  logic [15:0]          in_value,
    input  logic [16:0]          frame_rate,
    input  logic                 filter_enable,
    input  logic [15:0]          filter_alpha,
    output logic [15:0]          left_sample,
    output logic [15:0]          right_sample,
    output logic [3:0]           active_mask
);

    localparam int MEM_DEPTH = 1 << SAMPLE_ADDR_BITS;

    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] rd_data_reg;

    logic [1:0]  rtype_reg;

    logic [15:0] per_reg  [4];
    logic [6:0]  vol_reg  [4];
    logic [15:0] start_reg[4];
    logic [15:0] len_reg  [4];
    logic [15:0] lofs_reg [4];
    logic [15:0] llen_reg [4];
    logic [3:0]  en_reg;
    logic [31:0] pos_reg  [4];
    logic [31:0] step_reg [4];
    logic [3:0]  stepw_reg;

    logic        use_reg;       // channel contributes this frame
    logic signed [15:0] sum_l_reg, sum_r_reg;
    logic signed [31:0] lp_l_reg, lp_r_reg;
    logic signed [49:0] prod_l_reg, prod_r_reg;
    logic [15:0] out_l_reg, out_r_reg;
    logic [3:0]  mask_reg;

    logic        div_busy;
    logic [31:0] div_step;
    logic        div_busy_q;

    fcsm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.load_req && in_req_type == fcsm_pkg::REQ_REG
                  && in_reg_sel == fcsm_pkg::SEL_PERIOD),
        .period  (in_value),
        .rate    (frame_rate),
        .busy    (div_busy),
        .step    (div_step)
    );

    assign stat.req_type = rtype_reg;
    assign stat.div_busy = div_busy;
    assign stat.fen      = filter_enable;

    assign left_sample  = out_l_reg;
    assign right_sample = out_r_reg;
    assign active_mask  = mask_reg;

    // channel stage 0 combinational view
    logic [1:0]  c;
    logic [15:0] ipos;
    logic        c_live, c_wrap;
    logic [16:0] rd_idx;
    assign c      = cmd.ch_idx;
    assign c_live = en_reg[c] && per_reg[c] != 16'd0 && len_reg[c] != 16'd0;
    assign ipos   = pos_reg[c][31:16];
    assign c_wrap = ipos >= len_reg[c];
    assign rd_idx = {1'b0, start_reg[c]} + {1'b0, (c_wrap ? lofs_reg[c] : ipos)};

    always_ff @(posedge aclk) begin
        if (cmd.load_req && in_req_type == fcsm_pkg::REQ_SAMPLE) begin
            mem[SAMPLE_ADDR_BITS'({4'd0, in_address})] <= in_value[7:0];
        end
        if (cmd.ch_prep) begin
            rd_data_reg <= mem[SAMPLE_ADDR_BITS'({3'd0, rd_idx})];
        end
    end

    // filter arithmetic
    logic signed [33:0] x_l, x_r, d_l, d_r;
    logic signed [49:0] f_l, f_r;
    logic signed [33:0] y_l, y_r;
    logic signed [31:0] ns_l, ns_r;
    logic signed [7:0]  volc;
    logic signed [15:0] contrib;

    assign volc    = (vol_reg[c] > 7'd64) ? 8'sd64 : $signed({1'b0, vol_reg[c]});
    assign contrib = 16'($signed(rd_data_reg) * volc);

    assign x_l = 34'(sum_l_reg) <<< 16;
    assign x_r = 34'(sum_r_reg) <<< 16;
    assign d_l = x_l - 34'(lp_l_reg);
    assign d_r = x_r - 34'(lp_r_reg);
    assign f_l = prod_l_reg >>> 16;
    assign f_r = prod_r_reg >>> 16;
    assign ns_l = lp_l_reg + 32'(f_l);
    assign ns_r = lp_r_reg + 32'(f_r);
    assign y_l = filter_enable ? 34'(ns_l) : x_l;
    assign y_r = filter_enable ? 34'(ns_r) : x_r;

    function automatic logic [15:0] to_out(input logic signed [33:0] y);
        logic signed [33:0] cl;
        logic signed [49:0] p;
        logic [49:0] mag;
        logic [20:0] q;
        begin
            cl = y;
            if (y > 34'sd536870912) cl = 34'sd536870912;
            if (y < -34'sd536870912) cl = -34'sd536870912;
            p   = cl * 50'sd32767;
            mag = p[49] ? 50'(-p) : 50'(p);
            q   = 21'(mag >> 29);
            to_out = p[49] ? 16'(-q) : 16'(q);
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                per_reg[i]   <= '0;
                vol_reg[i]   <= '0;
                start_reg[i] <= '0;
                len_reg[i]   <= '0;
                lofs_reg[i]  <= '0;
                llen_reg[i]  <= '0;
                pos_reg[i]   <= '0;
                step_reg[i]  <= '0;
            end
            en_reg     <= '0;
            stepw_reg  <= '0;
            lp_l_reg   <= '0;
            lp_r_reg   <= '0;
            rtype_reg  <= '0;
            use_reg    <= 1'b0;
            div_busy_q <= 1'b0;
            mask_reg   <= '0;
        end else begin
            div_busy_q <= div_busy;
            if (cmd.load_req) begin
                rtype_reg <= in_req_type;
                if (in_req_type == fcsm_pkg::REQ_REG) begin
                    unique case (in_reg_sel)
                        fcsm_pkg::SEL_PERIOD: begin
                            per_reg[in_channel]   <= in_value;
                            stepw_reg[in_channel] <= 1'b1;
                        end
                        fcsm_pkg::SEL_VOLUME:   vol_reg[in_channel]   <= in_value[6:0];
                        fcsm_pkg::SEL_START:    start_reg[in_channel] <= in_value;
                        fcsm_pkg::SEL_LENGTH:   len_reg[in_channel]   <= in_value;
                        fcsm_pkg::SEL_LOOP_OFS: lofs_reg[in_channel]  <= in_value;
                        fcsm_pkg::SEL_LOOP_LEN: llen_reg[in_channel]  <= in_value;
                        fcsm_pkg::SEL_POSITION: pos_reg[in_channel]   <= {in_value, 16'd0};
                        fcsm_pkg::SEL_ACTIVE:   en_reg[in_channel]    <= in_value[0];
                        default: ;
                    endcase
                end
            end
            // divider done: deliver the step to the channel that asked
            if (div_busy_q && !div_busy) begin
                for (int i = 0; i < 4; i++) begin
                    if (stepw_reg[i]) step_reg[i] <= div_step;
                end
                stepw_reg <= '0;
            end
            if (cmd.ch_prep) begin
                use_reg <= 1'b0;
                if (c_live) begin
                    if (c_wrap && llen_reg[c] == 16'd0) begin
                        en_reg[c] <= 1'b0;
                    end else begin
                        use_reg <= 1'b1;
                        if (c_wrap) pos_reg[c] <= {lofs_reg[c], 16'd0};
                    end
                end
            end
            if (cmd.ch_acc && use_reg) begin
                pos_reg[c] <= pos_reg[c] + step_reg[c];
            end
            if (cmd.filt_fin) begin
                if (filter_enable) begin
                    lp_l_reg <= ns_l;
                    lp_r_reg <= ns_r;
                end
                mask_reg <= en_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            sum_l_reg <= '0;
            sum_r_reg <= '0;
        end
        if (cmd.ch_acc && use_reg) begin
            if (c == 2'd0 || c == 2'd3) sum_l_reg <= sum_l_reg + contrib;
            else                        sum_r_reg <= sum_r_reg + contrib;
        end
        if (cmd.filt_mul) begin
            prod_l_reg <= $signed({1'b0, filter_alpha}) * d_l;
            prod_r_reg <= $signed({1'b0, filter_alpha}) * d_r;
        end
        if (cmd.filt_fin) begin
            out_l_reg <= to_out(y_l);
            out_r_reg <= to_out(y_r);
        end
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the four-channel sample mixer: drives sample writes, channel
// register writes and mix beats with random gaps on both sides, predicts each
// mixed frame and compares it field by field with the block's output beat.
// ----------------------------------------------------------------------------

typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic [3:0]  mask;
} frame_t;

class mix_scoreboard;
    logic [7:0]  mem [int];
    logic [15:0] period [4];
    logic [6:0]  volume [4];
    logic [15:0] start [4];
    logic [15:0] length [4];
    logic [15:0] loop_ofs [4];
    logic [15:0] loop_len [4];
    logic        enabled [4];
    logic [31:0] position [4];
    logic [31:0] step [4];
    longint      lp_left;
    longint      lp_right;
    logic [16:0] rate;
    logic        fen;
    logic [15:0] alpha;
    frame_t      pending [$];
    int          errors;

    function new();
        for (int c = 0; c < 4; c++) begin
            period[c] = 0; volume[c] = 0; start[c] = 0; length[c] = 0;
            loop_ofs[c] = 0; loop_len[c] = 0; enabled[c] = 0;
            position[c] = 0; step[c] = 0;
        end
        lp_left = 0; lp_right = 0;
        rate = fcsm_pkg::RATE_RESET; fen = 1; alpha = fcsm_pkg::ALPHA_RESET;
        errors = 0;
    endfunction

    function logic [31:0] calc_step(logic [15:0] p);
        longint unsigned den, q;
        den = 2 * longint'(p) * longint'(rate);
        if (den == 0) return 0;
        q = (longint'(3546895) << 16) / den;
        if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
        return q[31:0];
    endfunction

    function longint lowpass(longint st, longint x);
        longint d, f;
        d = longint'(alpha) * (x - st);
        f = (d >= 0) ? (d >>> 16) : -((-d + 65535) >>> 16);
        return longint'(int'(st + f));
    endfunction

    function logic [15:0] scale_out(longint y);
        longint v;
        if (y > (64'sd1 << 29)) y = 64'sd1 << 29;
        if (y < -(64'sd1 << 29)) y = -(64'sd1 << 29);
        v = (y * 32767) / (64'sd1 << 29);
        return v[15:0];
    endfunction

    function void note_input(logic [39:0] d);
        logic [1:0]  kind;
        logic [1:0]  ch;
        logic [2:0]  sel;
        logic [15:0] addr, val;
        longint      sum [2];
        longint      yl, yr;
        logic [31:0] ipos;
        int          s, vol;
        frame_t      f;
        kind = d[1:0]; ch = d[3:2]; sel = d[6:4]; addr = d[22:7]; val = d[38:23];
        if (kind == fcsm_pkg::REQ_SAMPLE) begin
            mem[addr] = val[7:0];
            return;
        end
        if (kind == fcsm_pkg::REQ_REG) begin
            case (sel)
                fcsm_pkg::SEL_PERIOD:   begin
                    period[ch] = val; step[ch] = calc_step(val);
                end
                fcsm_pkg::SEL_VOLUME:   volume[ch] = val[6:0];
                fcsm_pkg::SEL_START:    start[ch] = val;
                fcsm_pkg::SEL_LENGTH:   length[ch] = val;
                fcsm_pkg::SEL_LOOP_OFS: loop_ofs[ch] = val;
                fcsm_pkg::SEL_LOOP_LEN: loop_len[ch] = val;
                fcsm_pkg::SEL_POSITION: position[ch] = {val, 16'd0};
                default:                enabled[ch] = val[0];
            endcase
            return;
        end
        if (kind != fcsm_pkg::REQ_MIX) return;
        sum[0] = 0; sum[1] = 0;
        for (int c = 0; c < 4; c++) begin
            if (!enabled[c] || period[c] == 0 || length[c] == 0) continue;
            ipos = position[c] >> 16;
            if (ipos >= length[c]) begin
                if (loop_len[c] > 0) begin
                    position[c] = {loop_ofs[c], 16'd0};
                    ipos = 32'(loop_ofs[c]);
                end else begin
                    enabled[c] = 0;
                    continue;
                end
            end
            s = mem.exists(16'(start[c] + ipos)) ? int'($signed(mem[16'(start[c] + ipos)])) : 0;
            vol = (volume[c] > 64) ? 64 : volume[c];
            sum[(c == 0 || c == 3) ? 0 : 1] += s * vol;
            position[c] += step[c];
        end
        yl = sum[0] * 65536;
        yr = sum[1] * 65536;
        if (fen) begin
            lp_left = lowpass(lp_left, yl);
            lp_right = lowpass(lp_right, yr);
            yl = lp_left; yr = lp_right;
        end
        f.left = scale_out(yl);
        f.right = scale_out(yr);
        for (int c = 0; c < 4; c++) f.mask[c] = enabled[c];
        pending.push_back(f);
    endfunction

    function void check_result(logic [39:0] d);
        frame_t f;
        if (pending.size() == 0) begin
            $display("%0t: unexpected frame %h", $time, d);
            errors++;
            return;
        end
        f = pending.pop_front();
        if (d[15:0] !== f.left) begin
            $display("%0t: left exp %h got %h", $time, f.left, d[15:0]); errors++;
        end
        if (d[31:16] !== f.right) begin
            $display("%0t: right exp %h got %h", $time, f.right, d[31:16]); errors++;
        end
        if (d[35:32] !== f.mask) begin
            $display("%0t: mask exp %h got %h", $time, f.mask, d[35:32]); errors++;
        end
    endfunction
endclass

module tb_top;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    mix_scoreboard mixer_sb;
    int            idle_cycles = 0;

    always #5 aclk = ~aclk;

    four_channel_sample_mixer_core u_dut (.*);

    // accepted beats observed at the clock edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) mixer_sb.note_input(s_tdata);
            if (m_tvalid && m_tready) mixer_sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver with random stalls, some stretches without
    always @(posedge aclk) begin
        int gap;
        if (aresetn && m_tvalid && m_tready) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (gap != 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
                m_tready <= 1;
            end
        end else if (aresetn && !m_tready) begin
            m_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles > 20000) begin
            $display("four_channel_sample_mixer_core test failed");
            $finish;
        end
    end

    // the beat stays valid after acceptance only when no gap follows
    task automatic send(logic [1:0] kind, logic [1:0] ch, logic [2:0] sel,
                        logic [15:0] addr, logic [15:0] val);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        s_tdata <= {1'b0, val, addr, sel, ch, kind};
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (gap != 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] data);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= data;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            fcsm_pkg::CFG_RATE: mixer_sb.rate = data[16:0];
            fcsm_pkg::CFG_FEN:  mixer_sb.fen = data[0];
            default:            mixer_sb.alpha = data[15:0];
        endcase
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (mixer_sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // point a channel at written memory: start + range stays in written bytes
    task automatic setup_channel(logic [1:0] ch, logic [15:0] base, int len);
        send(fcsm_pkg::REQ_REG, ch, fcsm_pkg::SEL_START, 0, base);
        send(fcsm_pkg::REQ_REG, ch, fcsm_pkg::SEL_LENGTH, 0, 16'(len));
        send(fcsm_pkg::REQ_REG, ch, fcsm_pkg::SEL_LOOP_OFS, 0,
             16'($urandom_range(0, len - 1)));
        send(fcsm_pkg::REQ_REG, ch, fcsm_pkg::SEL_LOOP_LEN, 0,
             16'($urandom_range(0, 1) ? 1 : 0));
        send(fcsm_pkg::REQ_REG, ch, fcsm_pkg::SEL_POSITION, 0,
             16'($urandom_range(0, len - 1)));
        send(fcsm_pkg::REQ_REG, ch, fcsm_pkg::SEL_VOLUME, 0,
             16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 16'hFFFF) :
                                             $urandom_range(0, 127)));
        send(fcsm_pkg::REQ_REG, ch, fcsm_pkg::SEL_PERIOD, 0,
             16'($urandom_range(0, 7) == 0 ? $urandom_range(0, 16'hFFFF) :
                                             $urandom_range(100, 900)));
        send(fcsm_pkg::REQ_REG, ch, fcsm_pkg::SEL_ACTIVE, 0,
             16'($urandom_range(0, 16'hFFFF) | 1));
    endtask

    initial begin
        int phase_rate [4] = '{8000, 96000, 44100, 22050};
        int phase_alpha [4] = '{0, 65535, 25258, 40000};
        logic [15:0] base;
        mixer_sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: memory extremes, one looping channel and one that ends
        for (int i = 0; i < 8; i++)
            send(fcsm_pkg::REQ_SAMPLE, 2'($urandom), 3'($urandom), 16'(i),
                 {8'($urandom), (i[0] ? 8'h80 : 8'h7F)});
        send(fcsm_pkg::REQ_SAMPLE, 0, 0, 16'hFFFF, 16'hFF81);
        send(fcsm_pkg::REQ_REG, 0, fcsm_pkg::SEL_START, 0, 16'hFFFF);
        send(fcsm_pkg::REQ_REG, 0, fcsm_pkg::SEL_LENGTH, 0, 2);
        send(fcsm_pkg::REQ_REG, 0, fcsm_pkg::SEL_LOOP_LEN, 0, 16'hFFFF);
        send(fcsm_pkg::REQ_REG, 0, fcsm_pkg::SEL_LOOP_OFS, 0, 5);      // offset past length
        send(fcsm_pkg::REQ_REG, 0, fcsm_pkg::SEL_VOLUME, 0, 16'hFFFF); // above full scale
        send(fcsm_pkg::REQ_REG, 0, fcsm_pkg::SEL_PERIOD, 0, 1);        // smallest nonzero period
        send(fcsm_pkg::REQ_REG, 0, fcsm_pkg::SEL_ACTIVE, 0, 16'hFFFE); // bit zero clear
        send(fcsm_pkg::REQ_REG, 0, fcsm_pkg::SEL_ACTIVE, 0, 16'h0001);
        send(fcsm_pkg::REQ_REG, 1, fcsm_pkg::SEL_START, 0, 0);
        send(fcsm_pkg::REQ_REG, 1, fcsm_pkg::SEL_LENGTH, 0, 4);
        send(fcsm_pkg::REQ_REG, 1, fcsm_pkg::SEL_VOLUME, 0, 64);
        send(fcsm_pkg::REQ_REG, 1, fcsm_pkg::SEL_PERIOD, 0, 16'hFFFF);
        send(fcsm_pkg::REQ_REG, 1, fcsm_pkg::SEL_POSITION, 0, 3);
        send(fcsm_pkg::REQ_REG, 1, fcsm_pkg::SEL_ACTIVE, 0, 1);
        send(fcsm_pkg::REQ_REG, 2, fcsm_pkg::SEL_ACTIVE, 0, 1);        // period zero, stays on
        for (int i = 0; i < 5; i++) send(fcsm_pkg::REQ_MIX, 0, 0, 0, 0);
        send(fcsm_pkg::REQ_UNUSED, 2'($urandom), 3'($urandom), 16'($urandom),
             16'($urandom));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            apb_write(fcsm_pkg::CFG_RATE, phase_rate[ph]);
            apb_write(fcsm_pkg::CFG_FEN, 32'(ph != 1));
            apb_write(fcsm_pkg::CFG_ALPHA, phase_alpha[ph]);
            for (int n = 0; n < 205; n++) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    send(fcsm_pkg::REQ_SAMPLE, 2'($urandom), 3'($urandom),
                         16'($urandom), 16'($urandom));
                end else if (r < 16) begin
                    base = 16'($urandom);
                    for (int k = 0; k < 8; k++)
                        send(fcsm_pkg::REQ_SAMPLE, 0, 0, 16'(base + k), 16'($urandom));
                    setup_channel(2'($urandom), base, $urandom_range(1, 8));
                end else if (r < 22) begin
                    // register write that keeps reads inside written memory
                    int sel;
                    sel = $urandom_range(0, 4);
                    case (sel)
                        0: send(fcsm_pkg::REQ_REG, 2'($urandom), fcsm_pkg::SEL_VOLUME,
                                16'($urandom), 16'($urandom));
                        1: send(fcsm_pkg::REQ_REG, 2'($urandom), fcsm_pkg::SEL_PERIOD,
                                16'($urandom), 16'($urandom_range(0, 16'hFFFF)));
                        2: send(fcsm_pkg::REQ_REG, 2'($urandom), fcsm_pkg::SEL_ACTIVE,
                                16'($urandom), 16'($urandom));
                        3: send(fcsm_pkg::REQ_REG, 2'($urandom), fcsm_pkg::SEL_POSITION,
                                16'($urandom), 16'($urandom_range(0, 1)));
                        default: send(fcsm_pkg::REQ_UNUSED, 2'($urandom), 3'($urandom),
                                      16'($urandom), 16'($urandom));
                    endcase
                end else begin
                    send(fcsm_pkg::REQ_MIX, 2'($urandom), 3'($urandom), 16'($urandom),
                         16'($urandom));
                end
            end
            drain();
        end

        if (mixer_sb.errors == 0 && mixer_sb.pending.size() == 0)
            $display("four_channel_sample_mixer_core test passed");
        else
            $display("four_channel_sample_mixer_core test failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/fcsm_pkg.sv
sv/fcsm_ctrl.sv
sv/fcsm_div.sv
sv/fcsm_datapath.sv
sv/four_channel_sample_mixer_core.sv
dv/tb_top.sv
